### src/ahlp_pkg.sv
// Shared types, codes and keyword tables of the archive header line parser.
// Depends on nothing; every other file takes its names from here by scope.
package ahlp_pkg;

   // Parse phases of the header line.
   typedef enum logic [3:0] {
      PH_VER      = 4'd0,
      PH_ID_SP    = 4'd1,
      PH_LEN      = 4'd2,
      PH_LEN_SP   = 4'd3,
      PH_TYPE     = 4'd4,
      PH_TYPE_SP  = 4'd5,
      PH_URI      = 4'd6,
      PH_URI_SP   = 4'd7,
      PH_DATE     = 4'd8,
      PH_DATE_SP  = 4'd9,
      PH_CTYPE    = 4'd10,
      PH_CTYPE_SP = 4'd11,
      PH_RECID    = 4'd12,
      PH_WANT_LF  = 4'd13,
      PH_DONE     = 4'd14,
      PH_ERR      = 4'd15
   } phase_type;

   // Error classes, first one wins.
   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_VERSION = 3'd1,
      ERR_LENGTH  = 3'd2,
      ERR_TYPE    = 3'd3,
      ERR_SYNTAX  = 3'd4
   } error_type;

   // Field tags.
   localparam logic [2:0] TagVersion = 3'd0;
   localparam logic [2:0] TagLength  = 3'd1;
   localparam logic [2:0] TagType    = 3'd2;
   localparam logic [2:0] TagUri     = 3'd3;
   localparam logic [2:0] TagDate    = 3'd4;
   localparam logic [2:0] TagCtype   = 3'd5;
   localparam logic [2:0] TagRecid   = 3'd6;
   localparam logic [2:0] TagSep     = 3'd7;

   localparam logic [3:0] KindUnknown = 4'd8;

   // Keywords are only tracked over this many leading bytes (12).
   localparam logic [3:0] MaxKeywordChars = 4'd12;

   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab   = 8'h09;
   localparam logic [7:0] ChCr    = 8'h0D;
   localparam logic [7:0] ChLf    = 8'h0A;
   localparam logic [7:0] ChZero  = 8'd48;
   localparam logic [7:0] ChNine  = 8'd57;

   localparam logic [63:0] VerText = "warc/0.9";

   // Keywords left aligned in 16 byte slots, space padded.
   localparam logic [127:0] KwText [8] = '{
      "warcinfo        ",
      "response        ",
      "request         ",
      "metadata        ",
      "revisit         ",
      "conversion      ",
      "continuation    ",
      "resource        "
   };
   localparam logic [3:0] KwLen [8] = '{
      4'd8, 4'd8, 4'd7, 4'd8, 4'd7, 4'd10, 4'd12, 4'd8
   };

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_line;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  field_tag;
      logic [7:0]  echo_byte;
      logic        line_done;
      logic        parse_error;
      logic [2:0]  error_kind;
      logic [3:0]  record_kind;
      logic [31:0] length_value;
      logic        length_overflow;
   } rsp_payload_type;

   // Parser state carried from byte to byte.
   typedef struct packed {
      phase_type   phase;
      logic [3:0]  pos;
      logic        ver_match;
      logic [7:0]  cands;
      logic [31:0] len;
      logic        ovf;
      logic [3:0]  kind;
      error_type   err;
   } parse_state_type;

   localparam parse_state_type ParseReset = '{
      phase:     PH_VER,
      pos:       4'd0,
      ver_match: 1'b1,
      cands:     8'hFF,
      len:       32'd0,
      ovf:       1'b0,
      kind:      KindUnknown,
      err:       ERR_NONE
   };

endpackage

### src/ahlp_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on ahlp_pkg for the payload types.
interface ahlp_req_if;
   logic                     valid;
   logic                     ready;
   ahlp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ahlp_rsp_if;
   logic                     valid;
   logic                     ready;
   ahlp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### src/ahlp_step.sv
// Next-state and result logic for one header byte.
// Depends on ahlp_pkg.
module ahlp_step (
   input  ahlp_pkg::parse_state_type state,
   input  ahlp_pkg::req_payload_type item,
   output ahlp_pkg::parse_state_type state_next,
   output ahlp_pkg::rsp_payload_type result
);

   function automatic logic [3:0] bump(input logic [3:0] p);
      bump = (p == 4'd15) ? p : p + 4'd1;
   endfunction

   function automatic logic [7:0] type_filter(input logic [7:0] c, input logic [3:0] p,
                                              input logic [7:0] b);
      logic [127:0] t;
      logic [7:0]   r;
      r = c;
      if (p >= ahlp_pkg::MaxKeywordChars) begin
         r = 8'h00;
      end else begin
         for (int k = 0; k < 8; k++) begin
            t = ahlp_pkg::KwText[k] << {p, 3'b000};
            if (p >= ahlp_pkg::KwLen[k] || t[127:120] != b) begin
               r[k] = 1'b0;
            end
         end
      end
      type_filter = r;
   endfunction

   ahlp_pkg::parse_state_type cur;
   ahlp_pkg::parse_state_type nxt;
   logic [7:0]  b;
   logic        sp;
   logic        dig;
   logic [2:0]  tag;
   logic [63:0] ver_sh;
   logic [35:0] len_wide;
   logic        kw_hit;
   logic [2:0]  kw_idx;

   assign b   = item.in_byte;
   assign sp  = (b == ahlp_pkg::ChSpace) || (b == ahlp_pkg::ChTab) ||
                (b == ahlp_pkg::ChCr) || (b == ahlp_pkg::ChLf);
   assign dig = (b >= ahlp_pkg::ChZero) && (b <= ahlp_pkg::ChNine);
   assign cur = item.start_line ? ahlp_pkg::ParseReset : state;

   // Expected version byte at the current position.
   assign ver_sh = ahlp_pkg::VerText << {cur.pos[2:0], 3'b000};

   // length * 10 + digit, four spare bits catch the overflow.
   assign len_wide = ({4'b0000, cur.len} << 3) + ({4'b0000, cur.len} << 1) +
                     {32'd0, b[3:0]};

   // First surviving keyword whose length equals the field length.
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 3'd0;
      for (int k = 0; k < 8; k++) begin
         if (!kw_hit && cur.cands[k] && ahlp_pkg::KwLen[k] == cur.pos) begin
            kw_hit = 1'b1;
            kw_idx = 3'(k);
         end
      end
   end

   always_comb begin
      nxt = cur;
      tag = ahlp_pkg::TagSep;
      case (cur.phase)
         ahlp_pkg::PH_VER: begin
            if (!sp) begin
               tag = ahlp_pkg::TagVersion;
               if (cur.pos >= 4'd8 || ver_sh[63:56] != b) begin
                  nxt.ver_match = 1'b0;
               end
               nxt.pos = bump(cur.pos);
            end else if (cur.ver_match && cur.pos == 4'd8) begin
               nxt.phase = ahlp_pkg::PH_ID_SP;
            end else begin
               nxt.err   = ahlp_pkg::ERR_VERSION;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         ahlp_pkg::PH_ID_SP, ahlp_pkg::PH_LEN: begin
            if (dig) begin
               tag       = ahlp_pkg::TagLength;
               nxt.phase = ahlp_pkg::PH_LEN;
               if (!cur.ovf) begin
                  if (len_wide[35:32] != 4'd0) begin
                     nxt.len = 32'hFFFF_FFFF;
                     nxt.ovf = 1'b1;
                  end else begin
                     nxt.len = len_wide[31:0];
                  end
               end
            end else if (sp) begin
               if (cur.phase == ahlp_pkg::PH_LEN) begin
                  nxt.phase = ahlp_pkg::PH_LEN_SP;
               end
            end else begin
               nxt.err   = ahlp_pkg::ERR_LENGTH;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         ahlp_pkg::PH_LEN_SP: begin
            if (!sp) begin
               tag       = ahlp_pkg::TagType;
               nxt.cands = type_filter(8'hFF, 4'd0, b);
               nxt.pos   = 4'd1;
               nxt.phase = ahlp_pkg::PH_TYPE;
            end
         end
         ahlp_pkg::PH_TYPE: begin
            if (!sp) begin
               tag       = ahlp_pkg::TagType;
               nxt.cands = type_filter(cur.cands, cur.pos, b);
               nxt.pos   = bump(cur.pos);
            end else if (kw_hit) begin
               nxt.kind  = {1'b0, kw_idx};
               nxt.phase = ahlp_pkg::PH_TYPE_SP;
            end else begin
               nxt.err   = ahlp_pkg::ERR_TYPE;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         ahlp_pkg::PH_TYPE_SP, ahlp_pkg::PH_URI: begin
            if (!sp) begin
               tag       = ahlp_pkg::TagUri;
               nxt.phase = ahlp_pkg::PH_URI;
            end else if (cur.phase == ahlp_pkg::PH_URI) begin
               nxt.phase = ahlp_pkg::PH_URI_SP;
            end
         end
         ahlp_pkg::PH_URI_SP, ahlp_pkg::PH_DATE: begin
            if (dig) begin
               tag       = ahlp_pkg::TagDate;
               nxt.phase = ahlp_pkg::PH_DATE;
            end else if (sp) begin
               if (cur.phase == ahlp_pkg::PH_DATE) begin
                  nxt.phase = ahlp_pkg::PH_DATE_SP;
               end
            end else begin
               nxt.err   = ahlp_pkg::ERR_SYNTAX;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         ahlp_pkg::PH_DATE_SP, ahlp_pkg::PH_CTYPE: begin
            if (!sp) begin
               tag       = ahlp_pkg::TagCtype;
               nxt.phase = ahlp_pkg::PH_CTYPE;
            end else if (cur.phase == ahlp_pkg::PH_CTYPE) begin
               nxt.phase = ahlp_pkg::PH_CTYPE_SP;
            end
         end
         ahlp_pkg::PH_CTYPE_SP: begin
            if (!sp) begin
               tag       = ahlp_pkg::TagRecid;
               nxt.phase = ahlp_pkg::PH_RECID;
            end
         end
         ahlp_pkg::PH_RECID: begin
            if (b == ahlp_pkg::ChCr) begin
               nxt.phase = ahlp_pkg::PH_WANT_LF;
            end else if (!sp) begin
               tag = ahlp_pkg::TagRecid;
            end else begin
               nxt.err   = ahlp_pkg::ERR_SYNTAX;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         ahlp_pkg::PH_WANT_LF: begin
            if (b == ahlp_pkg::ChLf) begin
               nxt.phase = ahlp_pkg::PH_DONE;
            end else begin
               nxt.err   = ahlp_pkg::ERR_SYNTAX;
               nxt.phase = ahlp_pkg::PH_ERR;
            end
         end
         default: begin
            // done or error: byte ignored
         end
      endcase
   end

   assign state_next = nxt;

   assign result.field_tag       = tag;
   assign result.echo_byte       = b;
   assign result.line_done       = (nxt.phase == ahlp_pkg::PH_DONE);
   assign result.parse_error     = (nxt.phase == ahlp_pkg::PH_ERR);
   assign result.error_kind      = nxt.err;
   assign result.record_kind     = nxt.kind;
   assign result.length_value    = nxt.len;
   assign result.length_overflow = nxt.ovf;

endmodule

### src/ahlp_rsp_fifo.sv
// Two-entry result buffer that drives the response channel.
// Depends on ahlp_pkg and ahlp_rsp_if.
module ahlp_rsp_fifo (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ahlp_pkg::rsp_payload_type push_data,
   output logic                      not_full,
   ahlp_rsp_if.source                rsp_chan
);

   ahlp_pkg::rsp_payload_type mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   assign pop              = rsp_chan.valid && rsp_chan.ready;
   assign rsp_chan.valid   = (count_ff != 2'd0);
   assign rsp_chan.payload = mem_ff[rd_ptr_ff];
   assign not_full         = (count_ff != 2'd2);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### src/archive_header_line_parser.sv
// Header line parser, one byte per transfer. Each result reaches rsp_chan through the
// input register, then the result buffer. Throughput: one byte per cycle while the
// result buffer has room, limited by the combinational state update loop.
// Synchronous active-high reset returns the parser to the version field, empties
// the input register and the two-entry result buffer; no clearing pass follows.
module archive_header_line_parser (
   input  logic     clock,
   input  logic     reset,
   ahlp_req_if.sink req_chan,
   ahlp_rsp_if.source rsp_chan
);

   // Input register.
   logic                      in_valid_ff;
   logic                      in_valid_in;
   ahlp_pkg::req_payload_type in_item_ff;
   ahlp_pkg::req_payload_type in_item_in;

   // Parser state, updated once per consumed byte.
   ahlp_pkg::parse_state_type state_ff;
   ahlp_pkg::parse_state_type state_in;
   ahlp_pkg::parse_state_type state_next;
   ahlp_pkg::rsp_payload_type step_result;

   logic buf_not_full;
   logic advance;
   logic req_take;

   // A byte moves from the input register into the result buffer whenever the
   // buffer has room; buf_not_full is registered, so ready has no path from
   // rsp_chan.ready.
   assign advance        = in_valid_ff && buf_not_full;
   assign req_chan.ready = !in_valid_ff || buf_not_full;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_chan.payload;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      state_in = advance ? state_next : state_ff;
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= ahlp_pkg::ParseReset;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   ahlp_step u_step (
      .state      (state_ff),
      .item       (in_item_ff),
      .state_next (state_next),
      .result     (step_result)
   );

   ahlp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_data (step_result),
      .not_full  (buf_not_full),
      .rsp_chan  (rsp_chan)
   );

endmodule

### tb/tb.sv
// Self-checking bench for archive_header_line_parser: header line bytes in, tagged bytes out.
// Depends on ahlp_pkg and the channel interfaces in ahlp_ifs; drives the block and checks
// every result against a behavioral copy of the parser kept in this file.
module tb;

   // Ways a generated header line can be damaged.
   typedef enum int {
      FLAW_NONE,
      FLAW_VERSION,
      FLAW_LENGTH,
      FLAW_TYPE,
      FLAW_DATE,
      FLAW_RECID_END,
      FLAW_NO_LF,
      FLAW_NOISE,
      FLAW_CUT
   } line_flaw_type;

   // One queued byte; hold makes the driver wait until all outstanding results are back.
   typedef struct packed {
      logic                      hold;
      ahlp_pkg::req_payload_type item;
   } feed_entry_type;

   localparam int RandomBytes = 1100;
   localparam int StallLimit  = 2000;  // cycles with no transfer on either channel
   localparam int DrainCycles = 20;    // settle time after the last result

   logic clock = 1'b0;
   logic reset;

   ahlp_req_if req_if ();
   ahlp_rsp_if rsp_if ();

   archive_header_line_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Behavioral parser: state of the line being tagged.
   // ---------------------------------------------------------------------------------------
   string version_id = "warc/0.9";
   string keywords [8] = '{"warcinfo", "response", "request", "metadata",
                           "revisit", "conversion", "continuation", "resource"};

   ahlp_pkg::phase_type cur_phase;
   logic [3:0]          cur_pos;     // bytes seen in current field, saturates at 15
   logic                ver_ok;
   logic [7:0]          kw_live;     // one bit per keyword still matching
   logic [31:0]         len_acc;
   logic                len_sat;
   logic [3:0]          kind_seen;
   ahlp_pkg::error_type err_seen;

   feed_entry_type            byte_feed [$];     // bytes still to be driven
   ahlp_pkg::rsp_payload_type line_results [$];  // predicted tags, oldest first
   logic [7:0]                line_draft [$];    // line under construction

   int bytes_sent     = 0;
   int results_seen   = 0;
   int mismatches     = 0;
   int lines_closed   = 0;
   int errors_latched = 0;
   int lines_built    = 0;

   function automatic logic is_sep(logic [7:0] b);
      return b == ahlp_pkg::ChSpace || b == ahlp_pkg::ChTab ||
             b == ahlp_pkg::ChCr || b == ahlp_pkg::ChLf;
   endfunction

   function automatic logic is_digit(logic [7:0] b);
      return b >= ahlp_pkg::ChZero && b <= ahlp_pkg::ChNine;
   endfunction

   function automatic void restart_line();
      cur_phase = ahlp_pkg::PH_VER;
      cur_pos   = 4'd0;
      ver_ok    = 1'b1;
      kw_live   = 8'hFF;
      len_acc   = 32'd0;
      len_sat   = 1'b0;
      kind_seen = ahlp_pkg::KindUnknown;
      err_seen  = ahlp_pkg::ERR_NONE;
   endfunction

   function automatic void fail_line(ahlp_pkg::error_type e);
      err_seen  = e;
      cur_phase = ahlp_pkg::PH_ERR;
   endfunction

   function automatic void bump_pos();
      if (cur_pos != 4'd15) cur_pos = cur_pos + 4'd1;
   endfunction

   // Decimal accumulate; once saturated the value is frozen for the rest of the line.
   function automatic void add_digit(logic [7:0] b);
      logic [63:0] wide;
      if (len_sat) return;
      wide = 64'(len_acc) * 64'd10 + 64'(b - ahlp_pkg::ChZero);
      if (wide > 64'hFFFF_FFFF) begin
         len_acc = 32'hFFFF_FFFF;
         len_sat = 1'b1;
      end else begin
         len_acc = wide[31:0];
      end
   endfunction

   // Narrow the keyword candidates by one byte; nothing survives past the tracked width.
   function automatic void track_keyword(logic [7:0] b);
      if (cur_pos >= ahlp_pkg::MaxKeywordChars) begin
         kw_live = 8'h00;
      end else begin
         for (int k = 0; k < 8; k++)
            if (cur_pos >= keywords[k].len() || keywords[k][cur_pos] != b)
               kw_live[k] = 1'b0;
      end
      bump_pos();
   endfunction

   // First live keyword whose full length equals the bytes seen wins.
   function automatic logic keyword_hit();
      for (int k = 0; k < 8; k++) begin
         if (kw_live[k] && keywords[k].len() == cur_pos) begin
            kind_seen = 4'(k);
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Consume one byte and return the tag the block should produce for it.
   function automatic ahlp_pkg::rsp_payload_type parse_byte(ahlp_pkg::req_payload_type rq);
      logic [7:0]                b;
      logic                      sep;
      logic                      dig;
      logic [2:0]                tag;
      ahlp_pkg::phase_type       was;
      ahlp_pkg::rsp_payload_type rs;
      b   = rq.in_byte;
      sep = is_sep(b);
      dig = is_digit(b);
      tag = ahlp_pkg::TagSep;
      if (rq.start_line) restart_line();
      was = cur_phase;
      case (cur_phase)
         ahlp_pkg::PH_VER: begin
            if (!sep) begin
               tag = ahlp_pkg::TagVersion;
               if (cur_pos >= 4'd8 || version_id[cur_pos] != b) ver_ok = 1'b0;
               bump_pos();
            end else if (ver_ok && cur_pos == 4'd8) begin
               cur_phase = ahlp_pkg::PH_ID_SP;
            end else begin
               fail_line(ahlp_pkg::ERR_VERSION);
            end
         end
         ahlp_pkg::PH_ID_SP, ahlp_pkg::PH_LEN: begin
            if (dig) begin
               tag = ahlp_pkg::TagLength;
               add_digit(b);
               cur_phase = ahlp_pkg::PH_LEN;
            end else if (sep) begin
               if (cur_phase == ahlp_pkg::PH_LEN) cur_phase = ahlp_pkg::PH_LEN_SP;
            end else begin
               fail_line(ahlp_pkg::ERR_LENGTH);
            end
         end
         ahlp_pkg::PH_LEN_SP: begin
            if (!sep) begin
               tag     = ahlp_pkg::TagType;
               cur_pos = 4'd0;
               kw_live = 8'hFF;
               track_keyword(b);
               cur_phase = ahlp_pkg::PH_TYPE;
            end
         end
         ahlp_pkg::PH_TYPE: begin
            if (!sep) begin
               tag = ahlp_pkg::TagType;
               track_keyword(b);
            end else if (keyword_hit()) begin
               cur_phase = ahlp_pkg::PH_TYPE_SP;
            end else begin
               fail_line(ahlp_pkg::ERR_TYPE);
            end
         end
         ahlp_pkg::PH_TYPE_SP, ahlp_pkg::PH_URI: begin
            if (!sep) begin
               tag = ahlp_pkg::TagUri;
               cur_phase = ahlp_pkg::PH_URI;
            end else if (cur_phase == ahlp_pkg::PH_URI) begin
               cur_phase = ahlp_pkg::PH_URI_SP;
            end
         end
         ahlp_pkg::PH_URI_SP, ahlp_pkg::PH_DATE: begin
            if (dig) begin
               tag = ahlp_pkg::TagDate;
               cur_phase = ahlp_pkg::PH_DATE;
            end else if (sep) begin
               if (cur_phase == ahlp_pkg::PH_DATE) cur_phase = ahlp_pkg::PH_DATE_SP;
            end else begin
               fail_line(ahlp_pkg::ERR_SYNTAX);
            end
         end
         ahlp_pkg::PH_DATE_SP, ahlp_pkg::PH_CTYPE: begin
            if (!sep) begin
               tag = ahlp_pkg::TagCtype;
               cur_phase = ahlp_pkg::PH_CTYPE;
            end else if (cur_phase == ahlp_pkg::PH_CTYPE) begin
               cur_phase = ahlp_pkg::PH_CTYPE_SP;
            end
         end
         ahlp_pkg::PH_CTYPE_SP: begin
            if (!sep) begin
               tag = ahlp_pkg::TagRecid;
               cur_phase = ahlp_pkg::PH_RECID;
            end
         end
         ahlp_pkg::PH_RECID: begin
            // CR goes straight to waiting for LF; any other separator is a syntax error
            if (b == ahlp_pkg::ChCr) cur_phase = ahlp_pkg::PH_WANT_LF;
            else if (!sep) tag = ahlp_pkg::TagRecid;
            else fail_line(ahlp_pkg::ERR_SYNTAX);
         end
         ahlp_pkg::PH_WANT_LF: begin
            if (b == ahlp_pkg::ChLf) cur_phase = ahlp_pkg::PH_DONE;
            else fail_line(ahlp_pkg::ERR_SYNTAX);
         end
         default: ;  // latched done or error: byte ignored
      endcase
      if (cur_phase == ahlp_pkg::PH_DONE && was != ahlp_pkg::PH_DONE) lines_closed++;
      if (cur_phase == ahlp_pkg::PH_ERR && was != ahlp_pkg::PH_ERR) errors_latched++;
      rs.field_tag       = tag;
      rs.echo_byte       = b;
      rs.line_done       = (cur_phase == ahlp_pkg::PH_DONE);
      rs.parse_error     = (cur_phase == ahlp_pkg::PH_ERR);
      rs.error_kind      = err_seen;
      rs.record_kind     = kind_seen;
      rs.length_value    = len_acc;
      rs.length_overflow = len_sat;
      return rs;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus: header lines built byte by byte, mostly well formed with random content.
   // ---------------------------------------------------------------------------------------
   function automatic logic [7:0] any_sep();
      case ($urandom_range(0, 3))
         0: return ahlp_pkg::ChSpace;
         1: return ahlp_pkg::ChTab;
         2: return ahlp_pkg::ChCr;
         default: return ahlp_pkg::ChLf;
      endcase
   endfunction

   function automatic logic [7:0] word_char();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_sep(b));
      return b;
   endfunction

   function automatic logic [7:0] bad_digit();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (is_sep(b) || is_digit(b));
      return b;
   endfunction

   function automatic logic [7:0] digit_char();
      return ahlp_pkg::ChZero + 8'($urandom_range(0, 9));
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) line_draft.push_back(s[i]);
   endfunction

   // Field separator run: usually one byte, sometimes a longer mix.
   function automatic void add_gap();
      int n;
      n = ($urandom_range(0, 99) < 80) ? 1 : $urandom_range(2, 5);
      repeat (n) line_draft.push_back(any_sep());
   endfunction

   function automatic void add_words(int n);
      repeat (n) line_draft.push_back(word_char());
   endfunction

   function automatic void add_digits(int n);
      repeat (n) line_draft.push_back(digit_char());
   endfunction

   // Replace the byte at idx with a different non-separator byte.
   function automatic void spoil_at(int idx);
      logic [7:0] b;
      do b = word_char(); while (b == line_draft[idx]);
      line_draft[idx] = b;
   endfunction

   // Move the draft into the feed; the first byte restarts the parser.
   function automatic void flush_draft(logic hold);
      feed_entry_type e;
      for (int i = 0; i < line_draft.size(); i++) begin
         e.hold            = (i == 0) ? hold : 1'b0;
         e.item.in_byte    = line_draft[i];
         e.item.start_line = (i == 0);
         byte_feed.push_back(e);
      end
      line_draft.delete();
   endfunction

   function automatic void build_line(logic hold);
      line_flaw_type flaw;
      int            mark;
      int            n;
      int            k;
      flaw = ($urandom_range(0, 99) < 60) ? FLAW_NONE
                                          : line_flaw_type'($urandom_range(1, 8));
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(3, 24)) line_draft.push_back(8'($urandom_range(0, 255)));
      end else begin
         // version id: one byte wrong, cut short (possibly empty), or one byte too long
         add_text(version_id);
         if (flaw == FLAW_VERSION) begin
            case ($urandom_range(0, 2))
               0: spoil_at($urandom_range(0, 7));
               1: repeat ($urandom_range(1, 8)) void'(line_draft.pop_back());
               default: line_draft.push_back(word_char());
            endcase
         end
         add_gap();

         // data length, including the saturation boundary
         mark = line_draft.size();
         n = $urandom_range(0, 99);
         if (n < 8) add_text("4294967295");
         else if (n < 14) add_text("4294967296");
         else if (n < 24) add_digits($urandom_range(11, 16));
         else add_digits($urandom_range(1, 6));
         if (flaw == FLAW_LENGTH)
            line_draft.insert($urandom_range(mark, line_draft.size()), bad_digit());
         add_gap();

         // record type: a keyword, or a near miss of one
         mark = line_draft.size();
         k = $urandom_range(0, 7);
         add_text(keywords[k]);
         if (flaw == FLAW_TYPE) begin
            case ($urandom_range(0, 3))
               0: void'(line_draft.pop_back());
               1: line_draft.push_back(word_char());  // "continuation" + 1 passes the width
               2: spoil_at($urandom_range(mark, line_draft.size() - 1));
               default: begin
                  while (line_draft.size() > mark) void'(line_draft.pop_back());
                  add_words($urandom_range(1, 14));
               end
            endcase
         end
         add_gap();

         add_words($urandom_range(1, 6));  // subject URI
         add_gap();

         mark = line_draft.size();
         add_digits($urandom_range(1, 4));  // creation date
         if (flaw == FLAW_DATE)
            line_draft.insert($urandom_range(mark, line_draft.size()), bad_digit());
         add_gap();

         add_words($urandom_range(1, 5));  // content type
         add_gap();
         add_words($urandom_range(1, 5));  // record id

         case (flaw)
            FLAW_RECID_END: begin
               case ($urandom_range(0, 2))
                  0: line_draft.push_back(ahlp_pkg::ChSpace);
                  1: line_draft.push_back(ahlp_pkg::ChTab);
                  default: line_draft.push_back(ahlp_pkg::ChLf);
               endcase
               add_words($urandom_range(0, 3));
            end
            FLAW_NO_LF: begin
               line_draft.push_back(ahlp_pkg::ChCr);
               do n = $urandom_range(0, 255); while (n == ahlp_pkg::ChLf);
               line_draft.push_back(8'(n));
            end
            default: begin
               line_draft.push_back(ahlp_pkg::ChCr);
               line_draft.push_back(ahlp_pkg::ChLf);
            end
         endcase

         // abandon the line part way; the next start byte must recover from any phase
         if (flaw == FLAW_CUT) begin
            n = $urandom_range(1, line_draft.size() - 1);
            while (line_draft.size() > n) void'(line_draft.pop_back());
         end
      end

      // trailing bytes with no restart: ignored once latched
      if ($urandom_range(0, 99) < 30)
         repeat ($urandom_range(1, 4)) line_draft.push_back(8'($urandom_range(0, 255)));
      flush_draft(hold);
      lines_built++;
   endfunction

   // Short directed lines: largest length that fits, longest keyword, top-bit bytes,
   // then a length field broken by a letter with a latched byte behind it.
   function automatic void build_directed();
      add_text(version_id);
      line_draft.push_back(ahlp_pkg::ChTab);
      add_text("4294967295");
      line_draft.push_back(ahlp_pkg::ChSpace);
      add_text("continuation");
      line_draft.push_back(ahlp_pkg::ChSpace);
      line_draft.push_back(8'hFF);
      line_draft.push_back(ahlp_pkg::ChLf);
      add_text("9");
      line_draft.push_back(ahlp_pkg::ChCr);
      line_draft.push_back(8'h80);
      line_draft.push_back(ahlp_pkg::ChSpace);
      add_text("z");
      line_draft.push_back(ahlp_pkg::ChCr);
      line_draft.push_back(ahlp_pkg::ChLf);
      flush_draft(1'b0);
      add_text(version_id);
      line_draft.push_back(ahlp_pkg::ChSpace);
      add_text("7x0");
      flush_draft(1'b0);
      lines_built += 2;
   endfunction

   // Pause lengths: mostly none or short, a few long; a calm stretch has none at all.
   function automatic int pick_pause(logic calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(11, 40);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Request driver: presents the head of the feed, predicts each byte on its transfer.
   // ---------------------------------------------------------------------------------------
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            line_results.push_back(parse_byte(req_if.payload));
            byte_feed.delete(0);
            bytes_sent++;
            gap_left = pick_pause(((bytes_sent / 100) % 5) == 2);
         end else if (!req_if.valid && gap_left > 0) begin
            gap_left--;
         end
         // a held byte waits until every predicted tag has been returned
         if (gap_left == 0 && byte_feed.size() != 0 &&
             !(byte_feed[0].hold && line_results.size() != 0)) begin
            req_if.valid   <= 1'b1;
            req_if.payload <= byte_feed[0].item;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Response monitor: random backpressure, checks each transfer against the oldest prediction.
   // ---------------------------------------------------------------------------------------
   int stall_left = 0;

   task automatic compare_result(ahlp_pkg::rsp_payload_type got,
                                 ahlp_pkg::rsp_payload_type want);
      if (got.field_tag !== want.field_tag) begin
         $error("field_tag expected %0d got %0d", want.field_tag, got.field_tag);
         mismatches++;
      end
      if (got.echo_byte !== want.echo_byte) begin
         $error("echo_byte expected %02h got %02h", want.echo_byte, got.echo_byte);
         mismatches++;
      end
      if (got.line_done !== want.line_done) begin
         $error("line_done expected %0b got %0b", want.line_done, got.line_done);
         mismatches++;
      end
      if (got.parse_error !== want.parse_error) begin
         $error("parse_error expected %0b got %0b", want.parse_error, got.parse_error);
         mismatches++;
      end
      if (got.error_kind !== want.error_kind) begin
         $error("error_kind expected %0d got %0d", want.error_kind, got.error_kind);
         mismatches++;
      end
      if (got.record_kind !== want.record_kind) begin
         $error("record_kind expected %0d got %0d", want.record_kind, got.record_kind);
         mismatches++;
      end
      if (got.length_value !== want.length_value) begin
         $error("length_value expected %0d got %0d", want.length_value, got.length_value);
         mismatches++;
      end
      if (got.length_overflow !== want.length_overflow) begin
         $error("length_overflow expected %0b got %0b",
                want.length_overflow, got.length_overflow);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (line_results.size() == 0) begin
               $error("result transfer with nothing outstanding, echo_byte %02h",
                      rsp_if.payload.echo_byte);
               mismatches++;
            end else begin
               compare_result(rsp_if.payload, line_results.pop_front());
            end
            stall_left = pick_pause(((results_seen / 100) % 5) == 4);
         end else if (!rsp_if.ready && stall_left > 0) begin
            stall_left--;
         end
         rsp_if.ready <= (stall_left == 0);
      end
   end

   // Watchdog: too long without any transfer on either channel ends the run.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= StallLimit) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Run control: build all stimulus, release reset, drain, report.
   // ---------------------------------------------------------------------------------------
   initial begin
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      rsp_if.ready   = 1'b0;
      reset          = 1'b1;
      restart_line();

      build_directed();
      // every twelfth line waits for a fully drained pipeline before its first byte
      while (byte_feed.size() < RandomBytes + 60)
         build_line((lines_built % 12) == 6);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (byte_feed.size() != 0 || line_results.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("tb: %0d bytes over %0d lines, %0d results checked", bytes_sent, lines_built,
               results_seen);
      $display("tb: %0d lines closed, %0d errors latched", lines_closed, errors_latched);
      if (mismatches == 0 && line_results.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
